/* src/vertex_rotate_bend_project_macros.svh */
`ifndef VERTEX_ROTATE_BEND_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_BEND_PROJECT_MACROS_SVH

`ifndef SYNTHESIS

`define VRBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex_rotate_bend_project: check failed");

`define VRBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex_rotate_bend_project: check failed");

`else

`define VRBP_ASSERT_IMP(label, ante, cons)

`define VRBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/vrbp_pkg.sv */
package vrbp_pkg;

    localparam int unsigned STAGES      = 12;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned SIN_FRAC    = 14;
    localparam int unsigned BEND_FRAC   = 22;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam int unsigned Z_W    = 40;
    localparam int unsigned ROT_W  = 44;
    localparam int unsigned PROD_W = 60;
    localparam int unsigned ZOOM_W = 61;

    localparam logic [17:0] MOD_OFFSET  = 18'd65540;
    localparam logic [15:0] RECIP_20    = 16'd52429;
    localparam logic [4:0]  BEND_PERIOD = 5'd20;

    localparam logic [2:0] REG_ROT_X       = 3'd0;
    localparam logic [2:0] REG_ROT_Y       = 3'd1;
    localparam logic [2:0] REG_ROT_Z       = 3'd2;
    localparam logic [2:0] REG_HEIGHT_GAIN = 3'd3;
    localparam logic [2:0] REG_BEND_GAIN   = 3'd4;
    localparam logic [2:0] REG_ZOOM        = 3'd5;
    localparam logic [2:0] REG_SHIFT_X     = 3'd6;
    localparam logic [2:0] REG_SHIFT_Y     = 3'd7;

    typedef struct packed {
        logic signed [15:0] grid_x;
        logic signed [15:0] grid_y;
        logic signed [15:0] grid_height;
        logic               color_given;
        logic [31:0]        vertex_color;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [15:0] height_out;
        logic               color_valid;
        logic [31:0]        color_out;
    } point_t;

    function automatic logic signed [15:0] sine_q14(input logic [4:0] idx);
        logic signed [15:0] val;
        case (idx)
            5'd0:    val = 16'sd0;
            5'd1:    val = 16'sd5063;
            5'd2:    val = 16'sd9630;
            5'd3:    val = 16'sd13255;
            5'd4:    val = 16'sd15582;
            5'd5:    val = 16'sd16384;
            5'd6:    val = 16'sd15582;
            5'd7:    val = 16'sd13255;
            5'd8:    val = 16'sd9630;
            5'd9:    val = 16'sd5063;
            5'd10:   val = 16'sd0;
            5'd11:   val = -16'sd5063;
            5'd12:   val = -16'sd9630;
            5'd13:   val = -16'sd13255;
            5'd14:   val = -16'sd15582;
            5'd15:   val = -16'sd16384;
            5'd16:   val = -16'sd15582;
            5'd17:   val = -16'sd13255;
            5'd18:   val = -16'sd9630;
            5'd19:   val = -16'sd5063;
            default: val = 16'sd0;
        endcase
        return val;
    endfunction

endpackage

/* src/vertex_rotate_bend_project.sv */
// Vertex transform: bend, three-axis rotation, zoom and screen offset.
// The pipeline has 12 register stages; a stalled output register fills bubbles behind it.
// Throughput: one item per cycle unless all stages are full and the output stalls.
// Each stage holds one multiply layer or one add-and-shift layer.
// Reset clears all stage valid bits and loads the register reset values; no clearing pass.
`include "vertex_rotate_bend_project_macros.svh"

module vertex_rotate_bend_project (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  vrbp_pkg::vertex_t vertex,
    output logic              point_valid,
    input  logic              point_stall,
    output vrbp_pkg::point_t  point,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int unsigned N = vrbp_pkg::STAGES;
    localparam logic signed [vrbp_pkg::ZOOM_W-1:0] TRUNC_BIAS =
        vrbp_pkg::ZOOM_W'((64'd1 << (vrbp_pkg::FRAC_BITS + 8)) - 64'd1);

    logic [31:0]        rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [15:0] height_gain_reg, bend_gain_reg;
    logic [15:0]        zoom_reg;
    logic signed [15:0] shift_x_reg, shift_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg       <= 32'd16384;
            rot_y_reg       <= 32'd16384;
            rot_z_reg       <= 32'd16384;
            height_gain_reg <= 16'sd256;
            bend_gain_reg   <= 16'sd0;
            zoom_reg        <= 16'd2560;
            shift_x_reg     <= 16'sd0;
            shift_y_reg     <= 16'sd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vrbp_pkg::REG_ROT_X:       rot_x_reg       <= cfg_data;
                vrbp_pkg::REG_ROT_Y:       rot_y_reg       <= cfg_data;
                vrbp_pkg::REG_ROT_Z:       rot_z_reg       <= cfg_data;
                vrbp_pkg::REG_HEIGHT_GAIN: height_gain_reg <= cfg_data[15:0];
                vrbp_pkg::REG_BEND_GAIN:   bend_gain_reg   <= cfg_data[15:0];
                vrbp_pkg::REG_ZOOM:        zoom_reg        <= cfg_data[15:0];
                vrbp_pkg::REG_SHIFT_X:     shift_x_reg     <= cfg_data[15:0];
                vrbp_pkg::REG_SHIFT_Y:     shift_y_reg     <= cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    logic signed [15:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

    assign cos_x = rot_x_reg[15:0];
    assign sin_x = rot_x_reg[31:16];
    assign cos_y = rot_y_reg[15:0];
    assign sin_y = rot_y_reg[31:16];
    assign cos_z = rot_z_reg[15:0];
    assign sin_z = rot_z_reg[31:16];

    // pipeline control
    logic [N-1:0] valid_reg;
    logic [N-1:0] stage_ready;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_ready
            assign stage_ready[g] = ~(point_stall & (&valid_reg[N-1:g]));
        end
    endgenerate

    assign vertex_stall = ~stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= vertex_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 0: height product and quotient of (x + y + MOD_OFFSET) by the bend period
    vrbp_pkg::vertex_t  pass_reg [N];
    vrbp_pkg::vertex_t  pass_next;
    logic signed [16:0] sum_c;
    logic [17:0]        u_next, u_reg;
    logic [33:0]        qprod_c;
    logic [12:0]        q_next, q_reg;
    logic signed [31:0] hprod_next, hprod_reg;

    always_comb
    begin
        pass_next = vertex;
        if (!vertex.color_given)
        begin
            pass_next.vertex_color = '0;
        end
    end

    assign sum_c      = 17'(vertex.grid_x) + 17'(vertex.grid_y);
    assign u_next     = 18'(sum_c) + vrbp_pkg::MOD_OFFSET;
    assign qprod_c    = 34'(u_next) * 34'(vrbp_pkg::RECIP_20);
    assign q_next     = 13'(qprod_c >> vrbp_pkg::RECIP_SHIFT);
    assign hprod_next = vertex.grid_height * height_gain_reg;

    // stage 1: table index and unbent depth
    logic [17:0]                   rem_c;
    logic [4:0]                    idx_next, idx_reg;
    logic signed [vrbp_pkg::Z_W-1:0] z0_next, z0_reg, z0b_reg;

    assign rem_c    = u_reg - 18'(q_reg) * 18'(vrbp_pkg::BEND_PERIOD);
    assign idx_next = rem_c[4:0];
    assign z0_next  = -(vrbp_pkg::Z_W'(hprod_reg) <<< (vrbp_pkg::FRAC_BITS - 8));

    // stage 2: bend product
    logic signed [31:0] bend_next, bend_reg;

    assign bend_next = bend_gain_reg * vrbp_pkg::sine_q14(idx_reg);

    // stage 3: bent depth
    logic signed [vrbp_pkg::Z_W-1:0] z1_next, z1_reg;

    assign z1_next = z0b_reg
                   - vrbp_pkg::Z_W'(bend_reg >>> (vrbp_pkg::BEND_FRAC - vrbp_pkg::FRAC_BITS));

    // stage 4: X-axis products
    logic signed [31:0]                 y0_c, x0_c;
    logic signed [vrbp_pkg::PROD_W-1:0] xa_yc_next, xa_zs_next, xa_ys_next, xa_zc_next;
    logic signed [vrbp_pkg::PROD_W-1:0] xa_yc_reg, xa_zs_reg, xa_ys_reg, xa_zc_reg;

    assign y0_c       = 32'(pass_reg[3].grid_y) <<< vrbp_pkg::FRAC_BITS;
    assign xa_yc_next = y0_c * cos_x;
    assign xa_zs_next = z1_reg * sin_x;
    assign xa_ys_next = y0_c * sin_x;
    assign xa_zc_next = z1_reg * cos_x;

    // stage 5: X-axis sums
    logic signed [vrbp_pkg::PROD_W-1:0] xa_y_sum, xa_z_sum;
    logic signed [vrbp_pkg::ROT_W-1:0]  y1_next, z2_next;
    logic signed [vrbp_pkg::ROT_W-1:0]  y1_reg, y1b_reg, y1c_reg, z2_reg;

    assign xa_y_sum = xa_yc_reg - xa_zs_reg;
    assign xa_z_sum = xa_ys_reg + xa_zc_reg;
    assign y1_next  = vrbp_pkg::ROT_W'(xa_y_sum >>> vrbp_pkg::SIN_FRAC);
    assign z2_next  = vrbp_pkg::ROT_W'(xa_z_sum >>> vrbp_pkg::SIN_FRAC);

    // stage 6: Y-axis products
    logic signed [vrbp_pkg::PROD_W-1:0] ya_xc_next, ya_zs_next, ya_xc_reg, ya_zs_reg;

    assign x0_c       = 32'(pass_reg[5].grid_x) <<< vrbp_pkg::FRAC_BITS;
    assign ya_xc_next = x0_c * cos_y;
    assign ya_zs_next = z2_reg * sin_y;

    // stage 7: Y-axis sum
    logic signed [vrbp_pkg::PROD_W-1:0] ya_x_sum;
    logic signed [vrbp_pkg::ROT_W-1:0]  x2_next, x2_reg;

    assign ya_x_sum = ya_xc_reg + ya_zs_reg;
    assign x2_next  = vrbp_pkg::ROT_W'(ya_x_sum >>> vrbp_pkg::SIN_FRAC);

    // stage 8: Z-axis products
    logic signed [vrbp_pkg::PROD_W-1:0] za_xc_next, za_ys_next, za_xs_next, za_yc_next;
    logic signed [vrbp_pkg::PROD_W-1:0] za_xc_reg, za_ys_reg, za_xs_reg, za_yc_reg;

    assign za_xc_next = x2_reg * cos_z;
    assign za_ys_next = y1c_reg * sin_z;
    assign za_xs_next = x2_reg * sin_z;
    assign za_yc_next = y1c_reg * cos_z;

    // stage 9: Z-axis sums
    logic signed [vrbp_pkg::PROD_W-1:0] za_x_sum, za_y_sum;
    logic signed [vrbp_pkg::ROT_W-1:0]  x3_next, y3_next, x3_reg, y3_reg;

    assign za_x_sum = za_xc_reg - za_ys_reg;
    assign za_y_sum = za_xs_reg + za_yc_reg;
    assign x3_next  = vrbp_pkg::ROT_W'(za_x_sum >>> vrbp_pkg::SIN_FRAC);
    assign y3_next  = vrbp_pkg::ROT_W'(za_y_sum >>> vrbp_pkg::SIN_FRAC);

    // stage 10: zoom
    logic signed [16:0]                 zoom_s;
    logic signed [vrbp_pkg::ZOOM_W-1:0] zx_next, zy_next, zx_reg, zy_reg;

    assign zoom_s  = $signed({1'b0, zoom_reg});
    assign zx_next = x3_reg * zoom_s;
    assign zy_next = y3_reg * zoom_s;

    // stage 11: truncate toward zero, offset
    logic signed [vrbp_pkg::ZOOM_W-1:0] zx_biased, zy_biased;
    logic signed [31:0]                 sx_next, sy_next, sx_reg, sy_reg;

    assign zx_biased = zx_reg + (zx_reg[vrbp_pkg::ZOOM_W-1] ? TRUNC_BIAS : '0);
    assign zy_biased = zy_reg + (zy_reg[vrbp_pkg::ZOOM_W-1] ? TRUNC_BIAS : '0);
    assign sx_next   = 32'(zx_biased >>> (vrbp_pkg::FRAC_BITS + 8)) + 32'(shift_x_reg);
    assign sy_next   = 32'(zy_biased >>> (vrbp_pkg::FRAC_BITS + 8)) + 32'(shift_y_reg);

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            pass_reg[0] <= pass_next;
            u_reg       <= u_next;
            q_reg       <= q_next;
            hprod_reg   <= hprod_next;
        end
        for (int k = 1; k < N; k++)
        begin
            if (stage_ready[k])
            begin
                pass_reg[k] <= pass_reg[k-1];
            end
        end
        if (stage_ready[1])
        begin
            idx_reg <= idx_next;
            z0_reg  <= z0_next;
        end
        if (stage_ready[2])
        begin
            bend_reg <= bend_next;
            z0b_reg  <= z0_reg;
        end
        if (stage_ready[3])
        begin
            z1_reg <= z1_next;
        end
        if (stage_ready[4])
        begin
            xa_yc_reg <= xa_yc_next;
            xa_zs_reg <= xa_zs_next;
            xa_ys_reg <= xa_ys_next;
            xa_zc_reg <= xa_zc_next;
        end
        if (stage_ready[5])
        begin
            y1_reg <= y1_next;
            z2_reg <= z2_next;
        end
        if (stage_ready[6])
        begin
            ya_xc_reg <= ya_xc_next;
            ya_zs_reg <= ya_zs_next;
            y1b_reg   <= y1_reg;
        end
        if (stage_ready[7])
        begin
            x2_reg  <= x2_next;
            y1c_reg <= y1b_reg;
        end
        if (stage_ready[8])
        begin
            za_xc_reg <= za_xc_next;
            za_ys_reg <= za_ys_next;
            za_xs_reg <= za_xs_next;
            za_yc_reg <= za_yc_next;
        end
        if (stage_ready[9])
        begin
            x3_reg <= x3_next;
            y3_reg <= y3_next;
        end
        if (stage_ready[10])
        begin
            zx_reg <= zx_next;
            zy_reg <= zy_next;
        end
        if (stage_ready[11])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign point_valid       = valid_reg[N-1];
    assign point.screen_x    = sx_reg;
    assign point.screen_y    = sy_reg;
    assign point.height_out  = pass_reg[N-1].grid_height;
    assign point.color_valid = pass_reg[N-1].color_given;
    assign point.color_out   = pass_reg[N-1].vertex_color;

    logic       in_only;
    logic [3:0] fill_count;

    assign in_only    = vertex_valid && !vertex_stall && !(point_valid && !point_stall);
    assign fill_count = 4'($countones(valid_reg));

    `VRBP_ASSERT_IMP(a_stall_only_when_full, vertex_stall, (&valid_reg) && point_stall)
    `VRBP_ASSERT_NEXT(a_item_count_grows, in_only, fill_count == $past(fill_count) + 4'd1)
    `VRBP_ASSERT_IMP(a_no_color_is_zero, point_valid && !point.color_valid, point.color_out == 32'd0)

endmodule

/* tb/sv/vertex_rotate_bend_project_tb.sv */
module vertex_rotate_bend_project_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int BURST_CYCLES    = 80;
    localparam int SINE_Q14 [20] = '{
        0, 5063, 9630, 13255, 15582, 16384, 15582, 13255, 9630, 5063,
        0, -5063, -9630, -13255, -15582, -16384, -15582, -13255, -9630, -5063
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              vertex_valid;
    logic              vertex_stall;
    vrbp_pkg::vertex_t vertex;
    logic              point_valid;
    logic              point_stall;
    vrbp_pkg::point_t  point;
    logic              cfg_write;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    logic [31:0]        rot_x_cs = 32'd16384;
    logic [31:0]        rot_y_cs = 32'd16384;
    logic [31:0]        rot_z_cs = 32'd16384;
    logic signed [15:0] height_gain_q = 16'sd256;
    logic signed [15:0] bend_gain_q = 16'sd0;
    logic [15:0]        zoom_q = 16'd2560;
    logic signed [15:0] shift_x_px = 16'sd0;
    logic signed [15:0] shift_y_px = 16'sd0;

    vrbp_pkg::vertex_t vertex_feed[$];
    vrbp_pkg::point_t  expected_points[$];

    int sender_idle_pct = 35;
    int receiver_idle_pct = 74;
    int burst_requests = 0;
    int bursts_seen;
    int burst_left;
    int accepted_items = 0;
    int checked_points = 0;
    int settings_loaded = 1;
    int mismatches = 0;

    vertex_rotate_bend_project dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint to_pixels(longint v);
        if (v < 0)
            return -((-v) >> (vrbp_pkg::FRAC_BITS + 8));
        return v >> (vrbp_pkg::FRAC_BITS + 8);
    endfunction

    function automatic vrbp_pkg::point_t project_vertex(vrbp_pkg::vertex_t v);
        longint gx, gy, gh, px, py, pz, t, c, s, bend, zm, hg, bg, sx, sy;
        longint phase;
        vrbp_pkg::point_t p;
        gx = v.grid_x;
        gy = v.grid_y;
        gh = v.grid_height;
        hg = height_gain_q;
        bg = bend_gain_q;
        zm = longint'(zoom_q);
        sx = shift_x_px;
        sy = shift_y_px;
        px = gx <<< vrbp_pkg::FRAC_BITS;
        py = gy <<< vrbp_pkg::FRAC_BITS;
        pz = -((gh * hg) <<< (vrbp_pkg::FRAC_BITS - 8));
        phase = (gx + gy) % 20;
        if (phase < 0)
            phase = phase + 20;
        bend = bg * longint'(SINE_Q14[phase]);
        bend = bend >>> (vrbp_pkg::BEND_FRAC - vrbp_pkg::FRAC_BITS);
        pz = pz - bend;

        c = shortint'(rot_x_cs[15:0]);
        s = shortint'(rot_x_cs[31:16]);
        t = py;
        py = (t * c - pz * s) >>> vrbp_pkg::SIN_FRAC;
        pz = (t * s + pz * c) >>> vrbp_pkg::SIN_FRAC;

        c = shortint'(rot_y_cs[15:0]);
        s = shortint'(rot_y_cs[31:16]);
        t = px;
        px = (t * c + pz * s) >>> vrbp_pkg::SIN_FRAC;
        pz = (pz * c - t * s) >>> vrbp_pkg::SIN_FRAC;

        c = shortint'(rot_z_cs[15:0]);
        s = shortint'(rot_z_cs[31:16]);
        t = px;
        px = (t * c - py * s) >>> vrbp_pkg::SIN_FRAC;
        py = (t * s + py * c) >>> vrbp_pkg::SIN_FRAC;

        px = to_pixels(px * zm) + sx;
        py = to_pixels(py * zm) + sy;
        p.screen_x    = px[31:0];
        p.screen_y    = py[31:0];
        p.height_out  = v.grid_height;
        p.color_valid = v.color_given;
        p.color_out   = v.color_given ? v.vertex_color : 32'd0;
        return p;
    endfunction

    function automatic vrbp_pkg::vertex_t make_vertex(int x, int y, int h, bit given,
                                                      logic [31:0] color);
        vrbp_pkg::vertex_t v;
        v.grid_x       = x[15:0];
        v.grid_y       = y[15:0];
        v.grid_height  = h[15:0];
        v.color_given  = given;
        v.vertex_color = color;
        return v;
    endfunction

    function automatic vrbp_pkg::vertex_t random_vertex();
        vrbp_pkg::vertex_t v;
        logic [95:0] raw;
        int x, y, h;
        raw = {$urandom, $urandom, $urandom};
        v = raw[$bits(vrbp_pkg::vertex_t)-1:0];
        if ($urandom_range(9) < 4)
        begin
            x = $urandom_range(300) - 50;
            y = $urandom_range(300) - 50;
            h = $urandom_range(200) - 100;
            v.grid_x      = x[15:0];
            v.grid_y      = y[15:0];
            v.grid_height = h[15:0];
        end
        return v;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            vrbp_pkg::REG_ROT_X:       rot_x_cs = value;
            vrbp_pkg::REG_ROT_Y:       rot_y_cs = value;
            vrbp_pkg::REG_ROT_Z:       rot_z_cs = value;
            vrbp_pkg::REG_HEIGHT_GAIN: height_gain_q = value[15:0];
            vrbp_pkg::REG_BEND_GAIN:   bend_gain_q = value[15:0];
            vrbp_pkg::REG_ZOOM:        zoom_q = value[15:0];
            vrbp_pkg::REG_SHIFT_X:     shift_x_px = value[15:0];
            vrbp_pkg::REG_SHIFT_Y:     shift_y_px = value[15:0];
            default:                   ;
        endcase
    endtask

    function automatic logic [31:0] random_rotation();
        int k;
        logic [15:0] c, s;
        if ($urandom_range(1))
            return $urandom;
        k = $urandom_range(19);
        c = 16'(SINE_Q14[(k + 5) % 20]);
        s = 16'(SINE_Q14[k]);
        return {s, c};
    endfunction

    task automatic load_random_settings();
        write_register(vrbp_pkg::REG_ROT_X, random_rotation());
        write_register(vrbp_pkg::REG_ROT_Y, random_rotation());
        write_register(vrbp_pkg::REG_ROT_Z, random_rotation());
        write_register(vrbp_pkg::REG_HEIGHT_GAIN,
                       $urandom_range(1) ? $urandom : $urandom_range(1024));
        write_register(vrbp_pkg::REG_BEND_GAIN, $urandom);
        write_register(vrbp_pkg::REG_ZOOM, $urandom_range(1) ? $urandom : $urandom_range(4096));
        write_register(vrbp_pkg::REG_SHIFT_X, $urandom);
        write_register(vrbp_pkg::REG_SHIFT_Y, $urandom);
        settings_loaded++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (vertex_feed.size() != 0 || vertex_valid || expected_points.size() != 0);
    endtask

    task automatic queue_directed();
        vertex_feed.push_back(make_vertex(0, 0, 0, 1'b0, 32'hFFFF_FFFF));
        vertex_feed.push_back(make_vertex(32767, 32767, 32767, 1'b1, 32'hFFFF_FFFF));
        vertex_feed.push_back(make_vertex(-32768, -32768, -32768, 1'b1, 32'h0000_0000));
        vertex_feed.push_back(make_vertex(-32768, 32767, 0, 1'b0, 32'h1234_5678));
        vertex_feed.push_back(make_vertex(32767, -32768, 1, 1'b1, 32'hA5A5_5A5A));
        vertex_feed.push_back(make_vertex(-7, -8, -1, 1'b1, 32'h5A5A_A5A5));
        vertex_feed.push_back(make_vertex(3, 2, 100, 1'b0, 32'h0000_0001));
        vertex_feed.push_back(make_vertex(-1, 0, -100, 1'b1, 32'h8000_0000));
        vertex_feed.push_back(make_vertex(10, 5, 32767, 1'b1, 32'h00FF_FF00));
        vertex_feed.push_back(make_vertex(-19, -1, -32768, 1'b0, 32'hDEAD_BEEF));
        vertex_feed.push_back(make_vertex(1, 0, 5, 1'b1, 32'h7FFF_FFFF));
        vertex_feed.push_back(make_vertex(14, 0, 0, 1'b0, 32'h0000_0000));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_valid <= 1'b0;
            vertex       <= '0;
        end
        else if (!(vertex_valid && vertex_stall))
        begin
            if (vertex_valid)
            begin
                expected_points.push_back(project_vertex(vertex));
                accepted_items++;
            end
            if (vertex_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                vertex_valid <= 1'b1;
                vertex       <= vertex_feed.pop_front();
            end
            else
                vertex_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_stall <= 1'b0;
            burst_left  <= 0;
            bursts_seen <= 0;
        end
        else if (bursts_seen != burst_requests)
        begin
            bursts_seen <= burst_requests;
            burst_left  <= BURST_CYCLES;
            point_stall <= 1'b1;
        end
        else if (burst_left != 0)
        begin
            burst_left  <= burst_left - 1;
            point_stall <= 1'b1;
        end
        else
            point_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && point_valid && !point_stall)
        begin
            if (expected_points.size() == 0)
            begin
                mismatches++;
                $error("point arrived with no vertex pending");
            end
            else
            begin
                vrbp_pkg::point_t want;
                want = expected_points.pop_front();
                check_field("screen_x", want.screen_x, point.screen_x);
                check_field("screen_y", want.screen_y, point.screen_y);
                check_field("height_out", 32'(want.height_out), 32'(point.height_out));
                check_field("color_valid", 32'(want.color_valid), 32'(point.color_valid));
                check_field("color_out", want.color_out, point.color_out);
                checked_points++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_quiet();

        write_register(vrbp_pkg::REG_ROT_X, 32'h8000_7FFF);
        write_register(vrbp_pkg::REG_ROT_Y, 32'h7FFF_8000);
        write_register(vrbp_pkg::REG_ROT_Z, 32'h2D41_2D41);
        write_register(vrbp_pkg::REG_HEIGHT_GAIN, 32'h0000_8000);
        write_register(vrbp_pkg::REG_BEND_GAIN, 32'h0000_7FFF);
        write_register(vrbp_pkg::REG_ZOOM, 32'h0000_FFFF);
        write_register(vrbp_pkg::REG_SHIFT_X, 32'h0000_7FFF);
        write_register(vrbp_pkg::REG_SHIFT_Y, 32'h0000_8000);
        settings_loaded++;
        queue_directed();
        wait_quiet();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 35;
                    receiver_idle_pct = 74;
                    load_random_settings();
                end
                1:
                begin
                    sender_idle_pct   = 74;
                    receiver_idle_pct = 35;
                    load_random_settings();
                end
                2:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    write_register(vrbp_pkg::REG_ROT_X, 32'h8000_8000);
                    write_register(vrbp_pkg::REG_ROT_Y, 32'h8000_8000);
                    write_register(vrbp_pkg::REG_ROT_Z, 32'h8000_8000);
                    write_register(vrbp_pkg::REG_HEIGHT_GAIN, 32'h0000_7FFF);
                    write_register(vrbp_pkg::REG_BEND_GAIN, 32'h0000_8000);
                    write_register(vrbp_pkg::REG_ZOOM, 32'h0000_0000);
                    write_register(vrbp_pkg::REG_SHIFT_X, 32'h0000_8000);
                    write_register(vrbp_pkg::REG_SHIFT_Y, 32'h0000_7FFF);
                    settings_loaded++;
                end
                default:
                    load_random_settings();
            endcase

            for (int i = 0; i < ITEMS_PER_PHASE / 2; i++)
                vertex_feed.push_back(random_vertex());
            // hold the sender until the pipeline has drained
            wait_quiet();
            if (phase == 2)
            begin
                write_register(vrbp_pkg::REG_ZOOM, $urandom);
                settings_loaded++;
            end
            if (phase == 3)
                burst_requests++;
            for (int i = 0; i < ITEMS_PER_PHASE / 2; i++)
                vertex_feed.push_back(random_vertex());
            wait_quiet();
        end

        repeat (vrbp_pkg::STAGES + 8) @(negedge clk);
        $display("Checked %0d points from %0d vertices over %0d register settings,",
                 checked_points, accepted_items, settings_loaded);
        $display("with random idling on both sides, an output stall burst and drain pauses.");
        if (mismatches == 0 && expected_points.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
